// ===== design/lzsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzsd_pkg: shared types and constants of the LZSS descriptor stream decoder
// Holds the port payload structs, the parser phases and the command format
// that passes from the parser to the copy engine.
// ----------------------------------------------------------------------------
package lzsd_pkg;

  localparam int WINDOW_SIZE_DEF = 8192;
  localparam int OUT_LANES_DEF   = 8;
  localparam int LANES_MAX       = 8;
  localparam int CMD_DEPTH       = 4;
  localparam int OUT_DEPTH       = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [7:0] out_byte4;
    logic [7:0] out_byte5;
    logic [7:0] out_byte6;
    logic [7:0] out_byte7;
    logic [3:0] valid_count;
    logic       last_of_run;
    logic       stream_end;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_CODE, PH_CODE2, PH_LIT, PH_INL_DIST, PH_INL_LEN, PH_HIGH, PH_LOW, PH_LONGLEN
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE, CMD_LIT, CMD_COPY, CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        restart;
    logic [7:0]  data;
    logic [13:0] distance;
    logic [8:0]  len;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_CLEAR, BK_IDLE, BK_READ, BK_WRITE
  } back_state_t;

endpackage

// ===== design/lzss_descriptor_stream_decoder.sv =====
// Flow: with the engine idle, a literal or end result passes through the command
// queue and then the result queue; a match takes its command from the queue and
// then does one memory read and one write per byte over the history port.
// Throughput: one byte per cycle into the command queue while in_full is low;
// sustained rate is set by the copy engine. Reset: history clear pass over all
// WINDOW_SIZE entries, in_full stays high throughout.
// ----------------------------------------------------------------------------
// lzss_descriptor_stream_decoder: LZSS descriptor stream decompressor
// Parser front end, command queue, copy engine with history, result queue.
// ----------------------------------------------------------------------------
module lzss_descriptor_stream_decoder #(
  parameter int WINDOW_SIZE = lzsd_pkg::WINDOW_SIZE_DEF,
  parameter int OUT_LANES   = lzsd_pkg::OUT_LANES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  lzsd_pkg::in_item_t  in_data,
  output logic                in_full,
  input  logic                out_pop,
  output lzsd_pkg::out_item_t out_data,
  output logic                out_empty
);
  lzsd_pkg::cmd_t      cmd_in, cmd_out;
  lzsd_pkg::out_item_t word;
  logic cmd_full, cmd_empty, cmd_pop, accept, clearing, res_push, res_full;

  assign in_full = cmd_full || clearing;
  assign accept  = in_push && !in_full;

  lzsd_front u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .in_item(in_data), .cmd(cmd_in)
  );

  lzsd_fifo #(.WIDTH($bits(lzsd_pkg::cmd_t)), .DEPTH(lzsd_pkg::CMD_DEPTH)) u_cmdq (
    .clk(clk), .rst_n(rst_n), .push(accept), .wdata(cmd_in), .full(cmd_full),
    .pop(cmd_pop), .rdata(cmd_out), .empty(cmd_empty)
  );

  lzsd_back #(.WINDOW_SIZE(WINDOW_SIZE), .OUT_LANES(OUT_LANES)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_out), .cmd_empty(cmd_empty),
    .cmd_pop(cmd_pop), .out_push(res_push), .out_word(word),
    .out_full(res_full), .clearing(clearing)
  );

  lzsd_fifo #(.WIDTH($bits(lzsd_pkg::out_item_t)), .DEPTH(lzsd_pkg::OUT_DEPTH)) u_resq (
    .clk(clk), .rst_n(rst_n), .push(res_push), .wdata(word), .full(res_full),
    .pop(out_pop), .rdata(out_data), .empty(out_empty)
  );
endmodule

// ===== design/lzsd_fifo.sv =====
// ----------------------------------------------------------------------------
// lzsd_fifo: small register queue
// First-in first-out buffer of flip-flops with full and empty flags.
// ----------------------------------------------------------------------------
module lzsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PLAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, rd_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  // store payload
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= wdata;
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PLAST) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == PLAST) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

// ===== design/lzsd_front.sv =====
// ----------------------------------------------------------------------------
// lzsd_front: descriptor parser
// Consumes one compressed byte per request and turns it into one command
// (none, literal, copy or end) for the copy engine.
// ----------------------------------------------------------------------------
module lzsd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  lzsd_pkg::in_item_t in_item,
  output lzsd_pkg::cmd_t     cmd
);
  lzsd_pkg::phase_t ph_r, ph_nxt;
  logic [7:0]  dbyte_r, dbyte_nxt;
  logic [3:0]  bits_r, bits_nxt;
  logic [7:0]  hb_r, hb_nxt;
  logic [13:0] dist_r, dist_nxt;
  logic        fin_r, fin_nxt;
  logic [7:0]  b;
  logic        bit_v;

  assign b = in_item.in_byte;

  // parse one byte, then drain descriptor bits
  always_comb begin
    ph_nxt    = in_item.stream_start ? lzsd_pkg::PH_CODE : ph_r;
    dbyte_nxt = in_item.stream_start ? 8'd0 : dbyte_r;
    bits_nxt  = in_item.stream_start ? 4'd0 : bits_r;
    hb_nxt    = in_item.stream_start ? 8'd0 : hb_r;
    dist_nxt  = in_item.stream_start ? 14'd0 : dist_r;
    fin_nxt   = in_item.stream_start ? 1'b0 : fin_r;
    cmd.kind     = lzsd_pkg::CMD_NONE;
    cmd.restart  = in_item.stream_start;
    cmd.data     = b;
    cmd.distance = 14'd0;
    cmd.len      = 9'd0;
    bit_v        = 1'b0;
    if (!fin_nxt) begin
      unique case (ph_nxt)
        lzsd_pkg::PH_CODE, lzsd_pkg::PH_CODE2, lzsd_pkg::PH_INL_LEN: begin
          dbyte_nxt = b;
          bits_nxt  = 4'd8;
        end
        lzsd_pkg::PH_LIT: begin
          cmd.kind = lzsd_pkg::CMD_LIT;
          ph_nxt   = lzsd_pkg::PH_CODE;
        end
        lzsd_pkg::PH_INL_DIST: begin
          dist_nxt = 14'h100 - {6'd0, b};
          hb_nxt   = 8'd1;
          ph_nxt   = lzsd_pkg::PH_INL_LEN;
        end
        lzsd_pkg::PH_HIGH: begin
          hb_nxt = b;
          ph_nxt = lzsd_pkg::PH_LOW;
        end
        lzsd_pkg::PH_LOW: begin
          dist_nxt = 14'h2000 - {1'b0, hb_nxt[7:3], b};
          if (hb_nxt[2:0] != 3'd0) begin
            cmd.kind     = lzsd_pkg::CMD_COPY;
            cmd.distance = dist_nxt;
            cmd.len      = 9'd10 - {6'd0, hb_nxt[2:0]};
            ph_nxt       = lzsd_pkg::PH_CODE;
          end else begin
            ph_nxt = lzsd_pkg::PH_LONGLEN;
          end
        end
        lzsd_pkg::PH_LONGLEN: begin
          if (b != 8'd0) begin
            cmd.kind     = lzsd_pkg::CMD_COPY;
            cmd.distance = dist_nxt;
            cmd.len      = {1'b0, b} + 9'd9;
            ph_nxt       = lzsd_pkg::PH_CODE;
          end else begin
            cmd.kind = lzsd_pkg::CMD_END;
            fin_nxt  = 1'b1;
          end
        end
        default: ph_nxt = lzsd_pkg::PH_CODE;
      endcase
      if (!fin_nxt) begin
        for (int i = 0; i < 8; i++) begin
          if ((ph_nxt == lzsd_pkg::PH_CODE || ph_nxt == lzsd_pkg::PH_CODE2 ||
               ph_nxt == lzsd_pkg::PH_INL_LEN) && bits_nxt != 4'd0) begin
            bit_v     = dbyte_nxt[7];
            dbyte_nxt = {dbyte_nxt[6:0], 1'b0};
            bits_nxt  = bits_nxt - 4'd1;
            if (ph_nxt == lzsd_pkg::PH_CODE) begin
              ph_nxt = bit_v ? lzsd_pkg::PH_LIT : lzsd_pkg::PH_CODE2;
            end else if (ph_nxt == lzsd_pkg::PH_CODE2) begin
              ph_nxt = bit_v ? lzsd_pkg::PH_HIGH : lzsd_pkg::PH_INL_DIST;
            end else begin
              hb_nxt = {hb_nxt[6:0], bit_v};
              if (hb_nxt >= 8'd4) begin
                cmd.kind     = lzsd_pkg::CMD_COPY;
                cmd.distance = dist_nxt;
                cmd.len      = {7'd0, hb_nxt[1:0]} + 9'd2;
                ph_nxt       = lzsd_pkg::PH_CODE;
              end
            end
          end
        end
      end
    end
  end

  // hold parser state between requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= lzsd_pkg::PH_CODE;
      dbyte_r <= '0;
      bits_r  <= '0;
      hb_r    <= '0;
      dist_r  <= '0;
      fin_r   <= 1'b0;
    end else if (accept) begin
      ph_r    <= ph_nxt;
      dbyte_r <= dbyte_nxt;
      bits_r  <= bits_nxt;
      hb_r    <= hb_nxt;
      dist_r  <= dist_nxt;
      fin_r   <= fin_nxt;
    end
  end
endmodule

// ===== design/lzsd_back.sv =====
// ----------------------------------------------------------------------------
// lzsd_back: copy engine
// Executes commands against the history memory and packs output bytes
// into result words.
// ----------------------------------------------------------------------------
module lzsd_back #(
  parameter int WINDOW_SIZE = lzsd_pkg::WINDOW_SIZE_DEF,
  parameter int OUT_LANES   = lzsd_pkg::OUT_LANES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lzsd_pkg::cmd_t      cmd,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  output logic                out_push,
  output lzsd_pkg::out_item_t out_word,
  input  logic                out_full,
  output logic                clearing
);
  localparam int AW = $clog2(WINDOW_SIZE);
  localparam logic [AW-1:0] WLAST = AW'(WINDOW_SIZE - 1);
  localparam logic [AW:0]   WEXT  = (AW+1)'(WINDOW_SIZE);
  localparam logic [3:0]    LLAST = 4'(OUT_LANES - 1);

  lzsd_pkg::back_state_t st_r, st_nxt;
  logic [7:0]  mem [WINDOW_SIZE];
  logic [AW-1:0] wp_r, wp_nxt, wp_eff, wa, ra;
  logic [AW:0]   d_r, d_nxt, dext, wext;
  logic [8:0]    rem_r, rem_nxt;
  logic [3:0]    lane_r, lane_nxt;
  logic [7:0]    word_r [lzsd_pkg::LANES_MAX];
  logic [7:0]    word_nxt [lzsd_pkg::LANES_MAX];
  logic [7:0]    wd, rd_q;
  logic          we, re;

  assign clearing = (st_r == lzsd_pkg::BK_CLEAR);
  assign wp_eff   = cmd.restart ? '0 : wp_r;
  assign dext     = {{(AW-13){1'b0}}, cmd.distance};
  assign wext     = {1'b0, wp_r};
  assign ra       = (wext >= d_r) ? AW'(wext - d_r) : AW'(wext + WEXT - d_r);

  // sequence commands
  always_comb begin
    st_nxt   = st_r;
    wp_nxt   = wp_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    lane_nxt = lane_r;
    word_nxt = word_r;
    cmd_pop  = 1'b0;
    out_push = 1'b0;
    out_word = '0;
    we = 1'b0;
    wa = wp_r;
    wd = rd_q;
    re = 1'b0;
    unique case (st_r)
      lzsd_pkg::BK_CLEAR: begin
        we     = 1'b1;
        wd     = 8'd0;
        wp_nxt = wp_r + 1'b1;
        if (wp_r == WLAST) begin
          wp_nxt = '0;
          st_nxt = lzsd_pkg::BK_IDLE;
        end
      end
      lzsd_pkg::BK_IDLE: begin
        if (!cmd_empty && !out_full) begin
          cmd_pop = 1'b1;
          wp_nxt  = wp_eff;
          unique case (cmd.kind)
            lzsd_pkg::CMD_LIT: begin
              we     = 1'b1;
              wa     = wp_eff;
              wd     = cmd.data;
              wp_nxt = (wp_eff == WLAST) ? '0 : wp_eff + 1'b1;
              out_push = 1'b1;
              out_word.out_byte0   = cmd.data;
              out_word.valid_count = 4'd1;
              out_word.last_of_run = 1'b1;
            end
            lzsd_pkg::CMD_END: begin
              out_push = 1'b1;
              out_word.last_of_run = 1'b1;
              out_word.stream_end  = 1'b1;
            end
            lzsd_pkg::CMD_COPY: begin
              d_nxt    = (dext >= WEXT) ? dext - WEXT : dext;
              rem_nxt  = cmd.len;
              lane_nxt = 4'd0;
              for (int i = 0; i < lzsd_pkg::LANES_MAX; i++) word_nxt[i] = 8'd0;
              st_nxt   = lzsd_pkg::BK_READ;
            end
            default: ;
          endcase
        end
      end
      lzsd_pkg::BK_READ: begin
        re     = 1'b1;
        st_nxt = lzsd_pkg::BK_WRITE;
      end
      lzsd_pkg::BK_WRITE: begin
        word_nxt[lane_r[2:0]] = rd_q;
        if (!((lane_r == LLAST || rem_r == 9'd1) && out_full)) begin
          we       = 1'b1;
          wp_nxt   = (wp_r == WLAST) ? '0 : wp_r + 1'b1;
          rem_nxt  = rem_r - 9'd1;
          lane_nxt = lane_r + 4'd1;
          st_nxt   = (rem_r == 9'd1) ? lzsd_pkg::BK_IDLE : lzsd_pkg::BK_READ;
          if (lane_r == LLAST || rem_r == 9'd1) begin
            out_push = 1'b1;
            out_word.out_byte0   = word_nxt[0];
            out_word.out_byte1   = word_nxt[1];
            out_word.out_byte2   = word_nxt[2];
            out_word.out_byte3   = word_nxt[3];
            out_word.out_byte4   = word_nxt[4];
            out_word.out_byte5   = word_nxt[5];
            out_word.out_byte6   = word_nxt[6];
            out_word.out_byte7   = word_nxt[7];
            out_word.valid_count = lane_r + 4'd1;
            out_word.last_of_run = (rem_r == 9'd1);
            lane_nxt = 4'd0;
            for (int i = 0; i < lzsd_pkg::LANES_MAX; i++) word_nxt[i] = 8'd0;
          end
        end else begin
          word_nxt = word_r;
        end
      end
      default: st_nxt = lzsd_pkg::BK_IDLE;
    endcase
  end

  // history memory
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  // hold payload of the running copy
  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    word_r <= word_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= lzsd_pkg::BK_CLEAR;
      wp_r   <= '0;
      lane_r <= '0;
    end else begin
      st_r   <= st_nxt;
      wp_r   <= wp_nxt;
      lane_r <= lane_nxt;
    end
  end
endmodule

// ===== verif/lzsd_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzsd_checker: result predictor and comparator for the LZSS stream decoder
// Watches accepted requests, decodes them into expected result words and
// compares every popped result word against the oldest expected one.
// ----------------------------------------------------------------------------
module lzsd_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  lzsd_pkg::in_item_t  in_data,
  input  logic                in_full,
  input  logic                out_pop,
  input  lzsd_pkg::out_item_t out_data,
  input  logic                out_empty,
  output int                  fail_count,
  output int                  words_pending
);
  localparam int WIN   = 8192;
  localparam int LANES = 8;

  logic [7:0]          hist [WIN];
  logic [12:0]         wptr;
  logic [7:0]          dbyte;
  logic [3:0]          dbits;
  lzsd_pkg::phase_t    phase;
  logic [7:0]          hbyte;
  logic [13:0]         mdist;
  logic [8:0]          mlen;
  logic                done;
  lzsd_pkg::out_item_t word_q [$];

  assign words_pending = word_q.size();

  function automatic void set_lane(ref lzsd_pkg::out_item_t w, input int lane,
                                   input logic [7:0] b);
    case (lane)
      0: w.out_byte0 = b;
      1: w.out_byte1 = b;
      2: w.out_byte2 = b;
      3: w.out_byte3 = b;
      4: w.out_byte4 = b;
      5: w.out_byte5 = b;
      6: w.out_byte6 = b;
      default: w.out_byte7 = b;
    endcase
  endfunction

  function automatic void restart();
    wptr = '0; dbyte = '0; dbits = '0; phase = lzsd_pkg::PH_CODE;
    hbyte = '0; mdist = '0; mlen = '0; done = 1'b0;
  endfunction

  // copy mlen bytes from mdist back, packing into result words
  task automatic copy_match();
    lzsd_pkg::out_item_t w;
    int lane;
    logic [7:0] b;
    lane = 0;
    w = '0;
    if (mlen > 264) mlen = 264;
    while (mlen > 0) begin
      b = hist[13'(wptr - mdist[12:0])];
      hist[wptr] = b;
      wptr = wptr + 1'b1;
      set_lane(w, lane, b);
      lane++;
      w.valid_count = 4'(lane);
      mlen = mlen - 1'b1;
      if (lane == LANES) begin
        if (mlen == 0) w.last_of_run = 1'b1;
        word_q.push_back(w);
        w = '0;
        lane = 0;
      end
    end
    if (lane != 0) begin
      w.last_of_run = 1'b1;
      word_q.push_back(w);
    end
  endtask

  // advance the decoder by one request
  task automatic decode_byte(input lzsd_pkg::in_item_t req);
    lzsd_pkg::out_item_t w;
    logic [7:0] b;
    logic bit_v;
    b = req.in_byte;
    if (req.stream_start) restart();
    if (done) return;
    case (phase)
      lzsd_pkg::PH_CODE, lzsd_pkg::PH_CODE2, lzsd_pkg::PH_INL_LEN: begin
        dbyte = b; dbits = 4'd8;
      end
      lzsd_pkg::PH_LIT: begin
        hist[wptr] = b; wptr = wptr + 1'b1;
        w = '0; w.out_byte0 = b; w.valid_count = 4'd1; w.last_of_run = 1'b1;
        word_q.push_back(w);
        phase = lzsd_pkg::PH_CODE;
      end
      lzsd_pkg::PH_INL_DIST: begin
        mdist = 14'(9'h100 - b);
        hbyte = 8'd1;
        phase = lzsd_pkg::PH_INL_LEN;
      end
      lzsd_pkg::PH_HIGH: begin
        hbyte = b;
        phase = lzsd_pkg::PH_LOW;
      end
      lzsd_pkg::PH_LOW: begin
        mdist = 14'h2000 - {1'b0, hbyte[7:3], b};
        if (hbyte[2:0] != 0) begin
          mlen = 9'(10 - hbyte[2:0]);
          copy_match();
          phase = lzsd_pkg::PH_CODE;
        end else phase = lzsd_pkg::PH_LONGLEN;
      end
      default: begin
        if (b != 0) begin
          mlen = 9'(b) + 9'd9;
          copy_match();
          phase = lzsd_pkg::PH_CODE;
        end else begin
          done = 1'b1;
          w = '0; w.last_of_run = 1'b1; w.stream_end = 1'b1;
          word_q.push_back(w);
          return;
        end
      end
    endcase
    while ((phase == lzsd_pkg::PH_CODE || phase == lzsd_pkg::PH_CODE2 ||
            phase == lzsd_pkg::PH_INL_LEN) && dbits > 0) begin
      bit_v = dbyte[7];
      dbyte = dbyte << 1;
      dbits = dbits - 1'b1;
      if (phase == lzsd_pkg::PH_CODE)
        phase = bit_v ? lzsd_pkg::PH_LIT : lzsd_pkg::PH_CODE2;
      else if (phase == lzsd_pkg::PH_CODE2)
        phase = bit_v ? lzsd_pkg::PH_HIGH : lzsd_pkg::PH_INL_DIST;
      else begin
        hbyte = {hbyte[6:0], bit_v};
        if (hbyte >= 4) begin
          mlen = 9'(hbyte[1:0]) + 9'd2;
          copy_match();
          phase = lzsd_pkg::PH_CODE;
        end
      end
    end
  endtask

  // predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    lzsd_pkg::out_item_t exp_w;
    if (!rst_n) begin
      for (int i = 0; i < WIN; i++) hist[i] = '0;
      restart();
      word_q.delete();
      fail_count <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (word_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $realtime, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = word_q.pop_front();
          if (out_data !== exp_w) begin
            $display("%0t: result mismatch expected %h actual %h", $realtime, exp_w, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_push && !in_full) decode_byte(in_data);
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top of the LZSS descriptor stream decoder testbench
// Feeds directed and random compressed streams with random idling on both
// sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  lzsd_pkg::in_item_t  in_data = '0;
  logic                in_full;
  logic                out_pop = 1'b0;
  lzsd_pkg::out_item_t out_data;
  logic                out_empty;
  int                  fail_count;
  int                  words_pending;
  logic                quiet_end = 1'b0;
  logic                hold_pop = 1'b0;
  lzsd_pkg::in_item_t  stim_q [$];

  always #5 clk = ~clk;

  lzss_descriptor_stream_decoder i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_pop(out_pop), .out_data(out_data), .out_empty(out_empty)
  );

  lzsd_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_pop(out_pop), .out_data(out_data), .out_empty(out_empty),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  // queue one request
  task automatic add(input logic [7:0] b, input logic st = 1'b0);
    lzsd_pkg::in_item_t r;
    r.in_byte = b;
    r.stream_start = st;
    stim_q.push_back(r);
  endtask

  // build a well-formed stream with random content
  task automatic add_stream(input int codes, input bit with_end);
    logic [7:0] d;
    int k;
    k = 0;
    while (k < codes) begin
      d = 8'($urandom);
      add(d, k == 0);
      for (int i = 0; i < 4 && k < codes; i++) begin
        if (d[7 - 2 * i]) add(8'($urandom));
        else if (!d[6 - 2 * i]) add(8'($urandom));
        else begin
          add(8'($urandom));
          add(8'($urandom));
          if (stim_q[$ - 1].in_byte[2:0] == 0) add(8'($urandom_range(1, 255)));
        end
        k++;
      end
    end
    if (with_end) begin
      add(8'h40);
      add(8'($urandom) & 8'hF8);
      add(8'($urandom));
      add(8'h00);
      add(8'($urandom));
    end
  endtask

  // sender: drive queued requests with random idle bursts
  initial begin
    int gap;
    lzsd_pkg::in_item_t r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed: literals, inline matches of length two, short separate
    // matches and far reach into cleared history
    add(8'hFF, 1'b1);
    for (int i = 0; i < 8; i++) add(i == 0 ? 8'h00 : 8'hFF - 8'(i));
    add(8'h00);
    add(8'h00); add(8'h00);
    add(8'h50);
    add(8'hFF); add(8'hFF);
    add(8'hFE);
    add(8'h1B);
    add(8'h07); add(8'h00);
    add(8'h00); add(8'hFF);
    add(8'h00); add(8'h00); add(8'h00);
    for (int s = 0; s < 24; s++) add_stream($urandom_range(3, 14), $urandom_range(0, 2) != 0);
    for (int i = 0; i < 30; i++) add(8'($urandom), $urandom_range(0, 9) == 0);
    while (stim_q.size() > 0) begin
      if (!quiet_end && stim_q.size() < 40) begin
        in_push <= 1'b0;
        while (words_pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        quiet_end <= 1'b1;
      end
      if (!quiet_end && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      r = stim_q.pop_front();
      in_push <= 1'b1;
      in_data <= r;
      @(posedge clk);
      while (in_full) @(posedge clk);
    end
    in_push <= 1'b0;
    while (words_pending != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (fail_count == 0) $display("** lzss_descriptor_stream_decoder: PASSED **");
    else $display("** lzss_descriptor_stream_decoder: FAILED **");
    $finish;
  end

  // long receiver hold-off early on so the block fills and stalls its input
  initial begin
    wait (rst_n);
    repeat (9000) @(posedge clk);
    hold_pop <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_pop <= 1'b0;
  end

  // receiver: pop with random stall bursts
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_pop) out_pop <= 1'b0;
      else if (!quiet_end && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 14);
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
        out_pop <= 1'b1;
      end else out_pop <= 1'b1;
    end
  end

  // timeout
  initial begin
    #20ms;
    $display("** lzss_descriptor_stream_decoder: FAILED **");
    $finish;
  end

endmodule
